// File: design/ascii_integer_parser_defines.svh
// ----------------------------------------------------------------------------
// ascii_integer_parser assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASCII_INTEGER_PARSER_DEFINES_SVH
`define ASCII_INTEGER_PARSER_DEFINES_SVH

// same-cycle implication
`define AIP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AIP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg
// Types, character codes and helpers of the ASCII integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

	localparam int CharW   = 8;
	localparam int RadixW  = 6;
	localparam int ValueW  = 64;
	localparam int OffsetW = 16;

	localparam longint unsigned MAX_OFFSET = 64'd65535;
	localparam logic [OffsetW-1:0] CountCap =
		OffsetW'((MAX_OFFSET < 64'd65535) ? MAX_OFFSET : 64'd65535);

	localparam logic [CharW-1:0] CharSpace = 8'h20;
	localparam logic [CharW-1:0] CharTab   = 8'h09;
	localparam logic [CharW-1:0] CharCr    = 8'h0D;
	localparam logic [CharW-1:0] CharPlus  = 8'h2B;
	localparam logic [CharW-1:0] CharMinus = 8'h2D;
	localparam logic [CharW-1:0] CharZero  = 8'h30;
	localparam logic [CharW-1:0] CharNine  = 8'h39;
	localparam logic [CharW-1:0] CharLowA  = 8'h61;
	localparam logic [CharW-1:0] CharLowZ  = 8'h7A;
	localparam logic [CharW-1:0] CharUpA   = 8'h41;
	localparam logic [CharW-1:0] CharUpZ   = 8'h5A;
	localparam logic [CharW-1:0] CharLowX  = 8'h78;
	localparam logic [CharW-1:0] CharUpX   = 8'h58;

	localparam logic [RadixW-1:0] RadixReset = 6'd10;
	localparam logic [RadixW-1:0] DecBase    = 6'd10;
	localparam logic [RadixW-1:0] OctBase    = 6'd8;
	localparam logic [RadixW-1:0] HexBase    = 6'd16;
	localparam logic [RadixW-1:0] MaxBase    = 6'd36;
	localparam logic [RadixW-1:0] UnaryBase  = 6'd1;

	typedef enum logic [4:0] {
		PH_SPACE  = 5'b00001,
		PH_FIRST  = 5'b00010,
		PH_ZERO   = 5'b00100,
		PH_HEXPFX = 5'b01000,
		PH_DIGITS = 5'b10000
	} phase_t;

	typedef struct packed {
		logic              ok;
		logic [RadixW-1:0] val;
	} digit_t;

	// map 0-9, a-z, A-Z to 0..35
	function automatic digit_t digit_value(input logic [CharW-1:0] c);
		digit_t d;
		d.ok  = 1'b1;
		d.val = '0;
		if (c >= CharZero && c <= CharNine) begin
			d.val = RadixW'(c - CharZero);
		end else if (c >= CharLowA && c <= CharLowZ) begin
			d.val = RadixW'(c - CharLowA) + DecBase;
		end else if (c >= CharUpA && c <= CharUpZ) begin
			d.val = RadixW'(c - CharUpA) + DecBase;
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

	function automatic logic is_space(input logic [CharW-1:0] c);
		return (c == CharSpace) || (c >= CharTab && c <= CharCr);
	endfunction

endpackage

// File: design/aip_char_if.sv
// ----------------------------------------------------------------------------
// aip_char_if
// Character request channel: one raw byte per request.
// ----------------------------------------------------------------------------
interface aip_char_if;
	logic                      valid;
	logic                      ready;
	logic [aip_pkg::CharW-1:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

// File: design/aip_result_if.sv
// ----------------------------------------------------------------------------
// aip_result_if
// Result request channel: parsed value and end offset of one number.
// ----------------------------------------------------------------------------
interface aip_result_if;
	logic                        valid;
	logic                        ready;
	logic [aip_pkg::ValueW-1:0]  parsed_value;
	logic [aip_pkg::OffsetW-1:0] end_offset;

	modport source (output valid, output parsed_value, output end_offset, input ready);
	modport sink (input valid, input parsed_value, input end_offset, output ready);
endinterface

// File: design/ascii_integer_parser.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Streaming strtoul-style converter from ASCII characters to a 64-bit value.
// ----------------------------------------------------------------------------
// Usage:
//   chr carries one character per request. Leading whitespace, one sign, an
//   optional 0x / 0 prefix and digits are consumed; the first other character
//   ends the number and is dropped. That character yields one request on res
//   with the value (negated after '-') and the count of consumed characters.
//   cfg_wr_en/cfg_wr_data write the radix (0 = detect from prefix); write it
//   only while no character is in flight.
// Timing:
//   A character is registered in char_s1, then decoded and folded into the parse
//   state by one 64x6 multiply-add; a result is registered on res from its
//   terminating character in char_s1. One character per cycle is sustained
//   unless a terminating character waits for res to free up (see Stall).
// Reset:
//   arst_n clears the parse state and both channels, and sets the radix to 10.
// Stall:
//   While a result waits on res, characters that do not end a number keep
//   flowing; a character that ends one waits in the input register, and chr
//   deasserts ready once that register is also held.
// ----------------------------------------------------------------------------
`include "ascii_integer_parser_defines.svh"

module ascii_integer_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [aip_pkg::RadixW-1:0]  cfg_wr_data,
	aip_char_if.sink                    chr,
	aip_result_if.source                res
);
	import aip_pkg::*;

	logic [RadixW-1:0]   radix_q;
	phase_t              phase_q;
	logic [ValueW-1:0]   acc_q;
	logic                neg_q;
	logic [RadixW-1:0]   base_q;
	logic [OffsetW-1:0]  cnt_q;

	logic                valid_s1;
	logic [CharW-1:0]    char_s1;

	logic                res_valid_q;
	logic [ValueW-1:0]   res_value_q;
	logic [OffsetW-1:0]  res_offset_q;

	phase_t              phase_d;
	logic [ValueW-1:0]   acc_d;
	logic                neg_d;
	logic [RadixW-1:0]   base_d;
	logic [OffsetW-1:0]  cnt_d;
	logic                emit;
	logic [ValueW-1:0]   emit_value;
	logic [OffsetW-1:0]  emit_offset;

	digit_t              dig;
	logic [ValueW-1:0]   mac;
	logic                out_free;
	logic                adv_s1;
	logic                take_in;

	assign dig      = digit_value(char_s1);
	// low 64 bits of the product wrap the value as required
	assign mac      = ValueW'(acc_q * base_q) + ValueW'(dig.val);

	assign out_free = !res_valid_q || res.ready;
	assign adv_s1   = valid_s1 && (!emit || out_free);
	assign take_in  = chr.valid && chr.ready;
	assign chr.ready = !valid_s1 || adv_s1;

	always_comb begin
		logic done;
		logic [RadixW-1:0] b;
		phase_d     = phase_q;
		acc_d       = acc_q;
		neg_d       = neg_q;
		base_d      = base_q;
		cnt_d       = cnt_q;
		emit        = 1'b0;
		emit_value  = '0;
		emit_offset = '0;
		done        = 1'b0;
		b           = '0;

		// unreachable codes fall back to a cleared whitespace phase
		if (!(phase_d == PH_SPACE || phase_d == PH_FIRST || phase_d == PH_ZERO ||
				phase_d == PH_HEXPFX || phase_d == PH_DIGITS)) begin
			phase_d = PH_SPACE;
			acc_d   = '0;
			neg_d   = 1'b0;
			base_d  = '0;
			cnt_d   = '0;
		end

		if (phase_d == PH_SPACE) begin
			base_d = radix_q;
			if (is_space(char_s1)) begin
				cnt_d = (cnt_d < CountCap) ? cnt_d + 1'b1 : cnt_d;
				done  = 1'b1;
			end else if (char_s1 == CharPlus || char_s1 == CharMinus) begin
				neg_d   = (char_s1 == CharMinus);
				cnt_d   = (cnt_d < CountCap) ? cnt_d + 1'b1 : cnt_d;
				phase_d = PH_FIRST;
				done    = 1'b1;
			end else begin
				phase_d = PH_FIRST;
			end
		end

		if (!done && phase_d == PH_FIRST) begin
			b = (base_d != '0) ? base_d : DecBase;
			if (base_d == UnaryBase || base_d > MaxBase) begin
				emit = 1'b1;
				done = 1'b1;
			end else if ((base_d == '0 || base_d == HexBase) && char_s1 == CharZero) begin
				acc_d   = '0;
				cnt_d   = (cnt_d < CountCap) ? cnt_d + 1'b1 : cnt_d;
				phase_d = PH_ZERO;
				done    = 1'b1;
			end else if (dig.ok && dig.val < b) begin
				base_d  = b;
				acc_d   = ValueW'(dig.val);
				cnt_d   = (cnt_d < CountCap) ? cnt_d + 1'b1 : cnt_d;
				phase_d = PH_DIGITS;
				done    = 1'b1;
			end else begin
				emit = 1'b1;
				done = 1'b1;
			end
		end

		if (!done && phase_d == PH_ZERO) begin
			if (char_s1 == CharLowX || char_s1 == CharUpX) begin
				base_d  = HexBase;
				cnt_d   = (cnt_d < CountCap) ? cnt_d + 1'b1 : cnt_d;
				phase_d = PH_HEXPFX;
				done    = 1'b1;
			end else begin
				if (base_d == '0) begin
					base_d = OctBase;
				end
				phase_d = PH_DIGITS;
			end
		end

		if (!done && phase_d == PH_HEXPFX) begin
			if (dig.ok && dig.val < HexBase) begin
				acc_d   = ValueW'(dig.val);
				cnt_d   = (cnt_d < CountCap) ? cnt_d + 1'b1 : cnt_d;
				phase_d = PH_DIGITS;
			end else begin
				// give back the 'x' unless the count is pinned
				emit        = 1'b1;
				emit_offset = (cnt_d >= CountCap) ? cnt_d : cnt_d - 1'b1;
			end
			done = 1'b1;
		end

		if (!done && phase_d == PH_DIGITS) begin
			if (dig.ok && dig.val < base_d) begin
				// acc_q is zero when arriving from the zero prefix
				acc_d = mac;
				cnt_d = (cnt_d < CountCap) ? cnt_d + 1'b1 : cnt_d;
			end else begin
				emit        = 1'b1;
				emit_value  = neg_d ? (~acc_d + 1'b1) : acc_d;
				emit_offset = cnt_d;
			end
		end

		if (emit) begin
			phase_d = PH_SPACE;
			acc_d   = '0;
			neg_d   = 1'b0;
			base_d  = '0;
			cnt_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RadixReset;
		end else if (cfg_wr_en) begin
			radix_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			base_q  <= '0;
			cnt_q   <= '0;
		end else if (adv_s1) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			base_q  <= base_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			char_s1 <= chr.char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			res_value_q  <= emit_value;
			res_offset_q <= emit_offset;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.parsed_value = res_value_q;
	assign res.end_offset   = res_offset_q;

	`AIP_ASSERT_NEXT(a_emit_clears, adv_s1 && emit,
		res_valid_q && phase_q == PH_SPACE && cnt_q == '0 && acc_q == '0 && !neg_q,
		"result not loaded or parse state not cleared after a terminating character")
	`AIP_ASSERT_NEXT(a_count_grows, adv_s1 && !emit, cnt_q >= $past(cnt_q),
		"consumed count dropped inside a number")
	`AIP_ASSERT_NEXT(a_s1_holds, valid_s1 && !adv_s1,
		valid_s1 && $stable(char_s1),
		"held character lost from the input register")
	`AIP_ASSERT_NOW(a_digit_base, phase_q == PH_DIGITS,
		base_q >= OctBase - 6'd6 && base_q <= MaxBase,
		"digit phase entered with an unusable base")

endmodule
